FILE: hw/rtl/tig_pkg.sv
`default_nettype none
package tig_pkg;

  localparam int unsigned AddrW   = 10;
  localparam int unsigned LenW    = 11;
  localparam int unsigned LowW    = 5;
  localparam int unsigned SeqLen  = 1024;

  localparam logic [LenW-1:0] FrameLenReset = LenW'(SeqLen);

  // Multiplier column of the n = 5 interleaver table, indexed by the low count bits.
  localparam logic [LowW-1:0] MultTable [32] = '{
    5'd27, 5'd3,  5'd1,  5'd15, 5'd13, 5'd17, 5'd23, 5'd13,
    5'd9,  5'd3,  5'd15, 5'd3,  5'd13, 5'd1,  5'd13, 5'd29,
    5'd21, 5'd19, 5'd1,  5'd3,  5'd29, 5'd17, 5'd25, 5'd29,
    5'd9,  5'd13, 5'd23, 5'd13, 5'd13, 5'd1,  5'd13, 5'd13
  };

  // One queued request, as classified by the front end.
  typedef struct packed {
    logic restart;
  } req_t;

  // Candidate address for one count: bit-reversed low part on top,
  // table entry times (high part + 1) mod 32 below.
  function automatic logic [AddrW-1:0] cand_addr(logic [AddrW-1:0] cnt);
    logic [LowW-1:0]   low;
    logic [LowW-1:0]   high;
    logic [LowW-1:0]   rev;
    logic [2*LowW-1:0] prod;
    low  = cnt[LowW-1:0];
    high = cnt[AddrW-1:LowW] + LowW'(1);
    for (int i = 0; i < LowW; i++) begin
      rev[LowW-1-i] = low[i];
    end
    prod = {{LowW{1'b0}}, MultTable[low]} * {{LowW{1'b0}}, high};
    return {rev, prod[LowW-1:0]};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tig_front.sv
`default_nettype none
module tig_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          restart_i,
  input  wire logic          pop_i,
  output logic               req_valid_o,
  output tig_pkg::req_t      req_o
);
  import tig_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign in_ready_o  = (count_q != CntW'(QueueDepth));
  assign req_valid_o = (count_q != '0);
  assign req_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].restart <= restart_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue did not grow on push");

endmodule
`default_nettype wire

FILE: hw/rtl/tig_back.sv
`default_nettype none
module tig_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [tig_pkg::LenW-1:0]    frame_len_i,
  input  wire logic                        req_valid_i,
  input  wire tig_pkg::req_t               req_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [tig_pkg::AddrW-1:0]        address_o,
  output logic [tig_pkg::AddrW-1:0]        position_o,
  output logic                             exhausted_o
);
  import tig_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic             state_q, state_d;
  logic [LenW-1:0]  counter_q, counter_d;
  logic [LenW-1:0]  emitted_q, emitted_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] address_q, address_d;
  logic [AddrW-1:0] position_q, position_d;
  logic             exhausted_q, exhausted_d;
  logic [AddrW-1:0] cand;
  logic             hit;
  logic             done_all;
  logic             out_free;

  assign cand     = cand_addr(counter_q[AddrW-1:0]);
  assign hit      = {1'b0, cand} < frame_len_i;
  assign done_all = counter_q[LenW-1];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    counter_d   = counter_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    address_d   = address_q;
    position_d  = position_q;
    exhausted_d = exhausted_q;
    pop_o       = 1'b0;
    case (state_q)
      StIdle: begin
        pop_o = req_valid_i;
        if (req_valid_i) begin
          state_d = StScan;
          if (req_i.restart) begin
            counter_d = '0;
            emitted_d = '0;
          end
        end
      end
      StScan: begin
        if (done_all) begin
          // Sequence used up: report exhaustion and return to idle once the output is free.
          if (out_free) begin
            out_valid_d = 1'b1;
            address_d   = '0;
            position_d  = '0;
            exhausted_d = 1'b1;
            state_d     = StIdle;
          end
        end else if (hit) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            address_d   = cand;
            position_d  = emitted_q[AddrW-1:0];
            exhausted_d = 1'b0;
            counter_d   = counter_q + LenW'(1);
            if (!emitted_q[LenW-1]) begin
              emitted_d = emitted_q + LenW'(1);
            end
            state_d     = StIdle;
          end
        end else begin
          // Pruned: advance to the next count.
          counter_d = counter_q + LenW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      counter_q   <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      counter_q   <= counter_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    address_q   <= address_d;
    position_q  <= position_d;
    exhausted_q <= exhausted_d;
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign position_o  = position_q;
  assign exhausted_o = exhausted_q;

  a_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q <= LenW'(SeqLen))
    else $error("sequence counter past end");

  a_emitted_le_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= counter_q)
    else $error("more addresses emitted than counts tested");

  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && exhausted_o) |-> (address_o == '0 && position_o == '0))
    else $error("exhausted result carries nonzero fields");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == StIdle && req_valid_i))
    else $error("request taken while scanning");

endmodule
`default_nettype wire

FILE: hw/rtl/turbo_interleaver_address_gen.sv
// Channel   Direction  Signals                                    Accepted when
// --------  ---------  -----------------------------------------  ------------------------
// in        input      in_valid_i, in_ready_o, restart_i          in_valid_i & in_ready_o
// out       output     out_valid_o, out_ready_i, address_o,       out_valid_o & out_ready_i
//                      position_o, exhausted_o
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_frame_length_i  cfg_valid_i & cfg_ready_o
//
// Flow: an item leaves the request queue in the idle state, then the scan unit tests
// one candidate per cycle, skipping pruned ones, until a hit or the counts run out.
// Reset: scan counter and emitted-position count clear to zero, frame length loads 1024; no clearing pass.
// Stalls: the request queue keeps accepting items while the scan runs, until it is full; a finished
// result waits in the output register, and the scan holds on a hit until it drains.
`default_nettype none
module turbo_interleaver_address_gen #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // request channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      restart_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [tig_pkg::AddrW-1:0]      address_o,
  output logic [tig_pkg::AddrW-1:0]      position_o,
  output logic                           exhausted_o,
  // frame length register write
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [tig_pkg::LenW-1:0]  cfg_frame_length_i
);
  import tig_pkg::*;

  logic [LenW-1:0] frame_len_q;
  logic            req_valid;
  req_t            req;
  logic            pop;

  // Always take register writes; the user must write only while the block is idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FrameLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_len_q <= cfg_frame_length_i;
    end
  end

  // Front end: accept requests and hold them until the scan unit is free.
  tig_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .pop_i       (pop),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // Back end: test one candidate per cycle while no hit waits on the output, drop pruned ones, register the result.
  tig_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_len_i (frame_len_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .address_o   (address_o),
    .position_o  (position_o),
    .exhausted_o (exhausted_o)
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(address_o)
      && $stable(position_o) && $stable(exhausted_o)))
    else $error("stalled result changed");

  a_in_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> !$fell(in_valid_i))
    else $error("request withdrawn before acceptance");

  a_cfg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> frame_len_q == $past(cfg_frame_length_i))
    else $error("frame length write lost");

endmodule
`default_nettype wire
